[design/rrs_pkg.sv]
// Shared types and constants for the rounded rectangle row span pipeline.
package rrs_pkg;

  // Sides saturate at this size before any other use.
  localparam logic [15:0] MAX_SIDE = 16'd4095;

  // Clamped radius is at most half of a 12 bit side, so 11 bits.
  localparam int RAD_W = 11;

  // One search stage for each bit of the corner inset.
  localparam int SEARCH_BITS = RAD_W;

  // Width of the squared-distance slack, 4r^2 - dy^2 < 2^24.
  localparam int SLACK_W = 24;

  // Work item carried down the search pipeline.
  typedef struct packed {
    logic                     ok;     // row holds a span before the width check
    logic signed [15:0]       x;      // left edge of the rectangle
    logic signed [16:0]       sy;     // screen row
    logic [11:0]              w;      // saturated width
    logic [RAD_W-1:0]         rs;     // search range, zero when no inset applies
    logic [SLACK_W-1:0]       slack;  // 4r^2 - dy^2 for this row
    logic [RAD_W-1:0]         acc;    // inset found so far
  } rrs_item_t;

endpackage

[design/rrs_setup.sv]
// Three setup stages: clamping and row classification, then the corner slack product.
module rrs_setup
  import rrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic signed [15:0] rect_x,
  input  logic signed [15:0] rect_y,
  input  logic [11:0]        rect_w,
  input  logic [11:0]        rect_h,
  input  logic [11:0]        corner_radius,
  input  logic [11:0]        row_index,
  output logic               vld_o,
  output rrs_item_t          item_o
);

  // Stage A: saturate sides, clamp radius, pick the corner distance.
  logic [11:0]      w_c;
  logic [11:0]      h_c;
  logic [11:0]      min_side;
  logic [RAD_W-1:0] max_r;
  logic [RAD_W-1:0] rad_c;
  logic [11:0]      dist_bot;
  logic             top_row;
  logic             bot_row;
  logic             corner;

  logic             a_vld_r;
  rrs_item_t        a_item_r;
  rrs_item_t        a_item_nxt;
  logic [RAD_W-1:0] a_d_r;
  logic [RAD_W-1:0] a_d_nxt;

  always_comb begin
    w_c      = (16'(rect_w) > MAX_SIDE) ? MAX_SIDE[11:0] : rect_w;
    h_c      = (16'(rect_h) > MAX_SIDE) ? MAX_SIDE[11:0] : rect_h;
    min_side = (w_c < h_c) ? w_c : h_c;
    max_r    = min_side[11:1];
    rad_c    = (corner_radius > {1'b0, max_r}) ? max_r : corner_radius[RAD_W-1:0];
    dist_bot = h_c - 12'd1 - row_index;
    top_row  = row_index < {1'b0, rad_c};
    bot_row  = row_index >= (h_c - {1'b0, rad_c});
    corner   = (rad_c != '0) && (top_row || bot_row);

    a_item_nxt.ok    = (w_c != 12'd0) && (h_c != 12'd0) && (row_index < h_c);
    a_item_nxt.x     = rect_x;
    a_item_nxt.sy    = {rect_y[15], rect_y} + {5'd0, row_index};
    a_item_nxt.w     = w_c;
    a_item_nxt.rs    = corner ? rad_c : '0;
    a_item_nxt.slack = '0;
    a_item_nxt.acc   = '0;
    a_d_nxt          = top_row ? row_index[RAD_W-1:0] : dist_bot[RAD_W-1:0];
  end

  // Stage B: factors of 4r^2 - (2r-1-2d)^2 = (2d+1)(4r-2d-1).
  logic             b_vld_r;
  rrs_item_t        b_item_r;
  logic [11:0]      b_fa_r;
  logic [11:0]      b_fa_nxt;
  logic [12:0]      b_fb_r;
  logic [12:0]      b_fb_nxt;

  always_comb begin
    b_fa_nxt = {a_d_r, 1'b1};
    b_fb_nxt = {a_item_r.rs, 2'b00} - {1'b0, a_d_r, 1'b0} - 13'd1;
  end

  // Stage C: the slack product.
  logic             c_vld_r;
  rrs_item_t        c_item_r;
  rrs_item_t        c_item_nxt;
  logic [24:0]      slack_full;

  always_comb begin
    slack_full       = {13'd0, b_fa_r} * {12'd0, b_fb_r};
    c_item_nxt       = b_item_r;
    c_item_nxt.slack = slack_full[SLACK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= vld_i;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r <= a_item_nxt;
      a_d_r    <= a_d_nxt;
      b_item_r <= a_item_r;
      b_fa_r   <= b_fa_nxt;
      b_fb_r   <= b_fb_nxt;
      c_item_r <= c_item_nxt;
    end
  end

  assign vld_o  = c_vld_r;
  assign item_o = c_item_r;

endmodule

[design/rrs_search_stage.sv]
// One bit of the corner inset search: tries setting bit BIT of the inset.
module rrs_search_stage
  import rrs_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_i,
  input  rrs_item_t item_i,
  output logic      vld_o,
  output rrs_item_t item_o
);

  logic [11:0]  cand;
  logic         fits;
  logic [11:0]  mag;
  logic [23:0]  sq;
  logic         take;

  logic         vld_r;
  rrs_item_t    item_r;
  rrs_item_t    item_nxt;

  // Column cand-1 lies outside the arc when |dx|^2 exceeds the slack,
  // so the inset is at least cand.
  always_comb begin
    cand         = {1'b0, item_i.acc} | (12'd1 << BIT);
    fits         = cand <= {1'b0, item_i.rs};
    mag          = {item_i.rs, 1'b0} + 12'd1 - {cand[RAD_W-1:0], 1'b0};
    sq           = {12'd0, mag} * {12'd0, mag};
    take         = fits && (sq > item_i.slack);
    item_nxt     = item_i;
    item_nxt.acc = take ? cand[RAD_W-1:0] : item_i.acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

[design/rounded_rect_row_span.sv]
// Top level of the rounded rectangle row span pipeline.
// This block takes one request per clock while in_stall is low: a rectangle with
// a corner radius and a row index, and returns the horizontal span that the
// rounded rectangle covers on that row. Every request gives exactly one result,
// with span_valid low and all other fields zero when the row is empty. Results
// come back in request order through three setup stages, an eleven stage inset
// search that decides one bit of the corner inset per stage, and the output
// register. Throughput is one request per cycle while the output side keeps up.
// When a result waits at the output and out_stall is high, the whole pipeline
// holds and in_stall is raised; no request is lost or repeated.
module rounded_rect_row_span
  import rrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_rect_x,
  input  logic signed [15:0] in_rect_y,
  input  logic [11:0]        in_rect_w,
  input  logic [11:0]        in_rect_h,
  input  logic [11:0]        in_corner_radius,
  input  logic [11:0]        in_row_index,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_span_x,
  output logic signed [16:0] out_span_y,
  output logic [11:0]        out_span_w,
  output logic               out_span_valid
);

  // The pipeline advances whenever the output register is free or being drained.
  logic en;

  logic              chain_vld  [0:SEARCH_BITS];
  rrs_item_t         chain_item [0:SEARCH_BITS];

  logic              out_valid_r;
  logic signed [16:0] span_x_r;
  logic signed [16:0] span_x_nxt;
  logic signed [16:0] span_y_r;
  logic signed [16:0] span_y_nxt;
  logic [11:0]       span_w_r;
  logic [11:0]       span_w_nxt;
  logic              span_valid_r;
  logic              span_valid_nxt;

  rrs_item_t         last;
  logic [11:0]       twice_inset;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  rrs_setup u_setup (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .vld_i         (in_valid),
    .rect_x        (in_rect_x),
    .rect_y        (in_rect_y),
    .rect_w        (in_rect_w),
    .rect_h        (in_rect_h),
    .corner_radius (in_corner_radius),
    .row_index     (in_row_index),
    .vld_o         (chain_vld[0]),
    .item_o        (chain_item[0])
  );

  // The search runs from the top bit of the inset down to bit zero.
  for (genvar k = 0; k < SEARCH_BITS; k++) begin : g_search
    rrs_search_stage #(
      .BIT (SEARCH_BITS - 1 - k)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (chain_vld[k]),
      .item_i (chain_item[k]),
      .vld_o  (chain_vld[k+1]),
      .item_o (chain_item[k+1])
    );
  end

  // Final step: the span is the width less the inset on both sides. A row that
  // has no pixels left, or that was empty from the start, reports all zeros.
  always_comb begin
    last           = chain_item[SEARCH_BITS];
    twice_inset    = {last.acc, 1'b0};
    span_valid_nxt = last.ok && (last.w > twice_inset);
    if (span_valid_nxt) begin
      span_x_nxt = {last.x[15], last.x} + {6'd0, last.acc};
      span_y_nxt = last.sy;
      span_w_nxt = last.w - twice_inset;
    end else begin
      span_x_nxt = '0;
      span_y_nxt = '0;
      span_w_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain_vld[SEARCH_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span_x_r     <= span_x_nxt;
      span_y_r     <= span_y_nxt;
      span_w_r     <= span_w_nxt;
      span_valid_r <= span_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_x     = span_x_r;
  assign out_span_y     = span_y_r;
  assign out_span_w     = span_w_r;
  assign out_span_valid = span_valid_r;

  // A drawn span always covers at least one pixel.
  a_span_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_span_valid) |-> (out_span_w != 12'd0))
    else $error("drawn span has zero width");

  // An empty row carries zero in every field.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_span_valid) |->
      (out_span_x == 17'sd0 && out_span_y == 17'sd0 && out_span_w == 12'd0))
    else $error("empty row carries nonzero fields");

  // A request leaving the last search stage on an advancing clock reaches the output.
  a_search_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_vld[SEARCH_BITS] && en) |=> out_valid)
    else $error("request from the search chain was dropped");

endmodule
